// ----- src/tcce_pkg.sv -----
// Types, codes and constants shared by the text console cursor engine.
// No dependencies; every other file in src/ imports this package.
package tcce_pkg;

  // Grid and history limits
  localparam logic [7:0] GridColsMax  = 8'd128;
  localparam logic [5:0] GridRowsMax  = 6'd48;
  localparam logic [7:0] HistoryDepth = 8'd200;

  // Register reset values
  localparam logic [7:0] ColsDefault = 8'd80;
  localparam logic [5:0] RowsDefault = 6'd25;
  localparam logic [3:0] FgDefault   = 4'd7;
  localparam logic [3:0] BgDefault   = 4'd0;

  localparam logic [2:0] TabStop = 3'd4;

  // Character codes
  localparam logic [7:0] ChBackspace = 8'd8;
  localparam logic [7:0] ChTab       = 8'd9;
  localparam logic [7:0] ChNewline   = 8'd10;
  localparam logic [7:0] ChSpace     = 8'h20;

  // Command queue depth, power of two
  localparam int unsigned QueueDepth = 4;

  typedef enum logic [1:0] {
    ACT_BYTE      = 2'd0,
    ACT_PAGE_UP   = 2'd1,
    ACT_PAGE_DOWN = 2'd2,
    ACT_CLEAR     = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    CFG_COLUMNS = 2'd0,
    CFG_ROWS    = 2'd1,
    CFG_FG      = 2'd2,
    CFG_BG      = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    KIND_CELL    = 3'd0,
    KIND_SCROLL  = 3'd1,
    KIND_VIEW    = 3'd2,
    KIND_CLEARED = 3'd3,
    KIND_CURSOR  = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    OP_CHAR      = 3'd0,
    OP_TAB       = 3'd1,
    OP_NEWLINE   = 3'd2,
    OP_BACKSPACE = 3'd3,
    OP_PAGE_UP   = 3'd4,
    OP_PAGE_DOWN = 3'd5,
    OP_CLEAR     = 3'd6
  } op_e;

  typedef enum logic [1:0] {
    ST_BEGIN  = 2'd0,
    ST_ACT    = 2'd1,
    ST_SCROLL = 2'd2,
    ST_CURSOR = 2'd3
  } step_e;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] char_code;
    logic       end_of_write;
  } in_item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [5:0] row;
    logic [6:0] col;
    logic [7:0] glyph;
    logic [3:0] fg;
    logic [3:0] bg;
    logic [7:0] view_offset;
    logic [7:0] history_count;
    logic       last;
  } out_item_t;

  // Classified command held in the queue
  typedef struct packed {
    op_e        op;
    logic [7:0] glyph;
    logic       eow;
  } cmd_t;

  // Effective (already clamped) grid settings and colours
  typedef struct packed {
    logic [7:0] cols;
    logic [5:0] rows;
    logic [3:0] fg;
    logic [3:0] bg;
  } grid_cfg_t;

endpackage

// ----- src/text_console_cursor_engine_core.sv -----
// Text console cursor engine: top level with configuration registers.
// Depends on tcce_pkg, tcce_front, tcce_fifo and tcce_back.
//
// A command is accepted every cycle while the four-entry command queue has
// room; the back end then emits each command's results in turn (a byte: its
// cell, with snap-to-live, scroll and cursor reports where they apply; a tab:
// a cell per pad space, a scroll per wrap on the last row, plus snap-to-live
// and cursor reports) and still takes a step for a command with no result.
// Sustained rate is therefore set by the back end's one-result-per-cycle
// sequencer while the output is not stalled. An accepted command goes through
// the command queue before its first result reaches the output register,
// which takes a new result in the same cycle the previous one is taken.
// Configuration writes must happen with the block idle; grid sizes out of
// range are clamped when written.
module text_console_cursor_engine_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  tcce_pkg::in_item_t   in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output tcce_pkg::out_item_t  out_item_o,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_index_i,
  input  logic [7:0]           cfg_data_i
);
  import tcce_pkg::*;

  localparam logic [7:0] ColsReset = (ColsDefault > GridColsMax) ? GridColsMax : ColsDefault;
  localparam logic [5:0] RowsReset = (RowsDefault > GridRowsMax) ? GridRowsMax : RowsDefault;

  grid_cfg_t cfg_q;
  logic      full, push, head_valid, pop;
  cmd_t      push_cmd, head_cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cols <= ColsReset;
      cfg_q.rows <= RowsReset;
      cfg_q.fg   <= FgDefault;
      cfg_q.bg   <= BgDefault;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_COLUMNS: begin
          if (cfg_data_i == '0)              cfg_q.cols <= 8'd1;
          else if (cfg_data_i > GridColsMax) cfg_q.cols <= GridColsMax;
          else                               cfg_q.cols <= cfg_data_i;
        end
        CFG_ROWS: begin
          if (cfg_data_i[5:0] == '0)              cfg_q.rows <= 6'd1;
          else if (cfg_data_i[5:0] > GridRowsMax) cfg_q.rows <= GridRowsMax;
          else                                    cfg_q.rows <= cfg_data_i[5:0];
        end
        CFG_FG:  cfg_q.fg <= cfg_data_i[3:0];
        CFG_BG:  cfg_q.bg <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  tcce_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .full_i     (full),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  tcce_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .pop_i   (pop),
    .full_o  (full),
    .valid_o (head_valid),
    .head_o  (head_cmd)
  );

  tcce_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_valid_i (head_valid),
    .head_i       (head_cmd),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_item_o   (out_item_o)
  );

`ifndef SYNTHESIS
  a_hist_capped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.history_count <= HistoryDepth))
    else $error("history count above depth");

  a_view_within_hist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.view_offset <= out_item_o.history_count))
    else $error("view offset beyond history");

  a_clear_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_item_o.kind == KIND_CLEARED)) |->
      (out_item_o.history_count == '0 && out_item_o.view_offset == '0 &&
       out_item_o.last))
    else $error("cleared result carries stale state");

  a_cell_in_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_item_o.kind == KIND_CELL)) |->
      ({1'b0, out_item_o.col} < cfg_q.cols && out_item_o.row < cfg_q.rows))
    else $error("cell write outside grid");
`endif

endmodule

// ----- src/tcce_front.sv -----
// Front end: takes input transactions and classifies them into queue commands.
// Depends on tcce_pkg.
module tcce_front (
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  tcce_pkg::in_item_t  in_item_i,
  input  logic                full_i,
  output logic                push_o,
  output tcce_pkg::cmd_t      cmd_o
);
  import tcce_pkg::*;

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;

  always_comb begin
    cmd_o.glyph = in_item_i.char_code;
    cmd_o.eow   = 1'b0;
    cmd_o.op    = OP_CLEAR;
    unique case (action_e'(in_item_i.action))
      ACT_BYTE: begin
        cmd_o.eow = in_item_i.end_of_write;
        if (in_item_i.char_code == ChNewline) begin
          cmd_o.op = OP_NEWLINE;
        end else if (in_item_i.char_code == ChTab) begin
          cmd_o.op    = OP_TAB;
          cmd_o.glyph = ChSpace;
        end else if (in_item_i.char_code == ChBackspace) begin
          cmd_o.op = OP_BACKSPACE;
        end else begin
          cmd_o.op = OP_CHAR;
        end
      end
      ACT_PAGE_UP:   cmd_o.op = OP_PAGE_UP;
      ACT_PAGE_DOWN: cmd_o.op = OP_PAGE_DOWN;
      ACT_CLEAR:     cmd_o.op = OP_CLEAR;
      default:       cmd_o.op = OP_CLEAR;
    endcase
  end

endmodule

// ----- src/tcce_fifo.sv -----
// Short command queue between front and back ends.
// Depends on tcce_pkg (cmd_t, QueueDepth).
module tcce_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  tcce_pkg::cmd_t  cmd_i,
  input  logic            pop_i,
  output logic            full_o,
  output logic            valid_o,
  output tcce_pkg::cmd_t  head_o
);
  import tcce_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  cmd_t            entry_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o  = (count_q == CntW'(QueueDepth));
  assign valid_o = (count_q != '0);
  assign head_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + PtrW'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + PtrW'(1);
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

// ----- src/tcce_back.sv -----
// Back end: executes queued commands, holds cursor/history/view state and
// drives the output register. Depends on tcce_pkg.
module tcce_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tcce_pkg::grid_cfg_t  cfg_i,
  input  logic                 head_valid_i,
  input  tcce_pkg::cmd_t       head_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output tcce_pkg::out_item_t  out_item_o
);
  import tcce_pkg::*;

  step_e      step_q, step_d;
  logic [6:0] col_q, col_d;
  logic [5:0] row_q, row_d;
  logic [7:0] hist_q, hist_d;
  logic [7:0] view_q, view_d;
  logic [2:0] pad_q, pad_d;

  logic       out_valid_q;
  out_item_t  out_q, res;
  logic       emit, done, view_step;
  logic       act_done;
  step_e      act_step;

  logic       advance, at_begin, is_byte, do_act;
  logic [6:0] col_cl, col_a;
  logic [5:0] row_cl, row_a;
  logic [2:0] pad_new, pad_a, pad_left;
  logic [7:0] col_inc;
  logic [6:0] row_inc;
  logic       wrap, row_end;
  logic [7:0] hist_inc;
  logic [8:0] view_up;
  logic       view_last;

  assign advance  = head_valid_i && (!out_valid_q || !out_stall_i);
  assign at_begin = (step_q == ST_BEGIN);
  assign is_byte  = (head_i.op == OP_CHAR) || (head_i.op == OP_TAB) ||
                    (head_i.op == OP_NEWLINE) || (head_i.op == OP_BACKSPACE);
  assign do_act   = advance &&
                    ((step_q == ST_ACT) || (at_begin && is_byte && (view_q == '0)));

  // cursor cut back into the grid before a byte is handled
  assign col_cl = ({1'b0, col_q} >= cfg_i.cols) ? 7'(cfg_i.cols - 8'd1) : col_q;
  assign row_cl = (row_q >= cfg_i.rows) ? (cfg_i.rows - 6'd1) : row_q;

  assign pad_new  = (head_i.op == OP_TAB) ? (TabStop - {1'b0, col_cl[1:0]}) : 3'd1;
  assign col_a    = at_begin ? col_cl : col_q;
  assign row_a    = at_begin ? row_cl : row_q;
  assign pad_a    = at_begin ? pad_new : pad_q;
  assign pad_left = pad_a - 3'd1;

  assign col_inc  = {1'b0, col_a} + 8'd1;
  assign wrap     = (col_inc >= cfg_i.cols);
  assign row_inc  = {1'b0, row_a} + 7'd1;
  assign row_end  = (row_inc >= {1'b0, cfg_i.rows});
  assign hist_inc = (hist_q < HistoryDepth) ? (hist_q + 8'd1) : hist_q;
  assign view_up  = {1'b0, view_q} + {3'b000, cfg_i.rows};

  // nothing follows the snap-to-live report
  assign view_last = !((head_i.op == OP_CHAR) || (head_i.op == OP_TAB) ||
                       ((head_i.op == OP_BACKSPACE) && (col_a != '0)) ||
                       ((head_i.op == OP_NEWLINE) && row_end) || head_i.eow);

  // where a character action goes next
  always_comb begin
    act_step = ST_BEGIN;
    act_done = 1'b0;
    unique case (head_i.op)
      OP_CHAR, OP_TAB: begin
        if (wrap && row_end) begin
          act_step = ST_SCROLL;
        end else if (pad_left != '0) begin
          act_step = ST_ACT;
        end else if (head_i.eow) begin
          act_step = ST_CURSOR;
        end else begin
          act_done = 1'b1;
        end
      end
      OP_NEWLINE: begin
        if (row_end && head_i.eow) act_step = ST_CURSOR;
        else                       act_done = 1'b1;
      end
      OP_BACKSPACE: begin
        if ((col_a != '0) && head_i.eow) act_step = ST_CURSOR;
        else                             act_done = 1'b1;
      end
      default: act_done = 1'b1;
    endcase
  end

  // next step
  always_comb begin
    step_d = step_q;
    done   = 1'b0;
    if (advance) begin
      unique case (step_q)
        ST_BEGIN: begin
          if (!is_byte) begin
            done = 1'b1;
          end else if (view_q != '0) begin
            step_d = ST_ACT;
          end else begin
            step_d = act_step;
            done   = act_done;
          end
        end
        ST_ACT: begin
          step_d = act_step;
          done   = act_done;
        end
        ST_SCROLL: begin
          if (pad_q != '0) begin
            step_d = ST_ACT;
          end else if (head_i.eow) begin
            step_d = ST_CURSOR;
          end else begin
            done = 1'b1;
          end
        end
        ST_CURSOR: done = 1'b1;
        default:   done = 1'b1;
      endcase
      if (done) step_d = ST_BEGIN;
    end
  end

  // results and state updates
  always_comb begin
    col_d     = col_q;
    row_d     = row_q;
    hist_d    = hist_q;
    view_d    = view_q;
    pad_d     = pad_q;
    emit      = 1'b0;
    view_step = 1'b0;
    res       = '0;
    if (advance) begin
      unique case (step_q)
        ST_BEGIN: begin
          unique case (head_i.op)
            OP_PAGE_UP: begin
              if (hist_q != '0) begin
                view_d   = (view_up > {1'b0, hist_q}) ? hist_q : view_up[7:0];
                emit     = 1'b1;
                res.kind = KIND_VIEW;
              end
            end
            OP_PAGE_DOWN: begin
              if (view_q != '0) begin
                view_d   = (view_q > {2'b00, cfg_i.rows}) ?
                           (view_q - {2'b00, cfg_i.rows}) : 8'd0;
                emit     = 1'b1;
                res.kind = KIND_VIEW;
              end
            end
            OP_CLEAR: begin
              col_d    = '0;
              row_d    = '0;
              hist_d   = '0;
              view_d   = '0;
              emit     = 1'b1;
              res.kind = KIND_CLEARED;
            end
            OP_CHAR, OP_TAB, OP_NEWLINE, OP_BACKSPACE: begin
              if (view_q != '0) begin
                col_d     = col_cl;
                row_d     = row_cl;
                pad_d     = pad_new;
                view_d    = '0;
                emit      = 1'b1;
                view_step = 1'b1;
                res.kind  = KIND_VIEW;
              end
            end
            default: ;
          endcase
        end
        ST_SCROLL: begin
          row_d    = cfg_i.rows - 6'd1;
          hist_d   = hist_inc;
          emit     = 1'b1;
          res.kind = KIND_SCROLL;
        end
        ST_CURSOR: begin
          emit     = 1'b1;
          res.kind = KIND_CURSOR;
          res.row  = row_q;
          res.col  = col_q;
        end
        default: ;
      endcase

      if (do_act) begin
        col_d = col_a;
        row_d = row_a;
        unique case (head_i.op)
          OP_CHAR, OP_TAB: begin
            emit      = 1'b1;
            res.kind  = KIND_CELL;
            res.row   = row_a;
            res.col   = col_a;
            res.glyph = head_i.glyph;
            res.fg    = cfg_i.fg;
            res.bg    = cfg_i.bg;
            pad_d     = pad_left;
            if (wrap) begin
              col_d = '0;
              // the scroll step moves the row when the grid is full
              if (!row_end) row_d = row_inc[5:0];
            end else begin
              col_d = col_inc[6:0];
            end
          end
          OP_NEWLINE: begin
            col_d = '0;
            if (row_end) begin
              row_d    = cfg_i.rows - 6'd1;
              hist_d   = hist_inc;
              emit     = 1'b1;
              res.kind = KIND_SCROLL;
            end else begin
              row_d = row_inc[5:0];
              if (head_i.eow) begin
                emit     = 1'b1;
                res.kind = KIND_CURSOR;
                res.row  = row_inc[5:0];
              end
            end
          end
          OP_BACKSPACE: begin
            if (col_a != '0) begin
              col_d     = col_a - 7'd1;
              emit      = 1'b1;
              res.kind  = KIND_CELL;
              res.row   = row_a;
              res.col   = col_a - 7'd1;
              res.glyph = ChSpace;
              res.fg    = cfg_i.fg;
              res.bg    = cfg_i.bg;
            end else if (head_i.eow) begin
              emit     = 1'b1;
              res.kind = KIND_CURSOR;
              res.row  = row_a;
              res.col  = col_a;
            end
          end
          default: ;
        endcase
      end
    end
    res.view_offset   = view_d;
    res.history_count = hist_d;
    res.last          = view_step ? view_last : done;
  end

  assign pop_o = done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= ST_BEGIN;
      col_q       <= '0;
      row_q       <= '0;
      hist_q      <= '0;
      view_q      <= '0;
      pad_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      step_q <= step_d;
      col_q  <= col_d;
      row_q  <= row_d;
      hist_q <= hist_d;
      view_q <= view_d;
      pad_q  <= pad_d;
      if (!out_valid_q || !out_stall_i) begin
        out_valid_q <= advance && emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if ((!out_valid_q || !out_stall_i) && advance && emit) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for the text console cursor engine.
// Depends on tcce_pkg and text_console_cursor_engine_core; a scoreboard class
// predicts every result transaction from the accepted commands.
module tb_top;
  import tcce_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned SettleCycles  = 16;
  localparam int unsigned MaxPerCommand = 10;

  class console_scoreboard;
    logic [7:0]  cols_reg;
    logic [5:0]  rows_reg;
    logic [3:0]  fg_reg;
    logic [3:0]  bg_reg;
    int unsigned cur_col;
    int unsigned cur_row;
    int unsigned hist_lines;
    int unsigned view_back;
    out_item_t   pending_events[$];
    out_item_t   step_events[$];
    int unsigned errors;

    function new();
      cols_reg   = ColsDefault;
      rows_reg   = RowsDefault;
      fg_reg     = FgDefault;
      bg_reg     = BgDefault;
      cur_col    = 0;
      cur_row    = 0;
      hist_lines = 0;
      view_back  = 0;
      errors     = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [7:0] data);
      case (idx)
        CFG_COLUMNS: cols_reg = data;
        CFG_ROWS:    rows_reg = data[5:0];
        CFG_FG:      fg_reg   = data[3:0];
        default:     bg_reg   = data[3:0];
      endcase
    endfunction

    function int unsigned grid_cols();
      if (cols_reg == 0) return 1;
      if (cols_reg > GridColsMax) return GridColsMax;
      return cols_reg;
    endfunction

    function int unsigned grid_rows();
      if (rows_reg == 0) return 1;
      if (rows_reg > GridRowsMax) return GridRowsMax;
      return rows_reg;
    endfunction

    function void push(kind_e k, int unsigned r, int unsigned c, int unsigned g,
                       logic [3:0] f, logic [3:0] b);
      out_item_t o;
      if (step_events.size() >= MaxPerCommand) return;
      o.kind          = k;
      o.row           = 6'(r);
      o.col           = 7'(c);
      o.glyph         = 8'(g);
      o.fg            = f;
      o.bg            = b;
      o.view_offset   = 8'(view_back);
      o.history_count = 8'(hist_lines);
      o.last          = 1'b0;
      step_events.push_back(o);
    endfunction

    // leaving the last row scrolls the grid and feeds the history
    function void line_feed();
      cur_row++;
      if (cur_row >= grid_rows()) begin
        if (hist_lines < HistoryDepth) hist_lines++;
        cur_row = grid_rows() - 1;
        push(KIND_SCROLL, 0, 0, 0, '0, '0);
      end
    endfunction

    function void write_cell(logic [7:0] g);
      push(KIND_CELL, cur_row, cur_col, g, fg_reg, bg_reg);
      cur_col++;
      if (cur_col >= grid_cols()) begin
        cur_col = 0;
        line_feed();
      end
    endfunction

    function void note_input(in_item_t it);
      int unsigned pad;
      out_item_t   o;
      step_events.delete();
      case (action_e'(it.action))
        ACT_BYTE: begin
          // grid may have shrunk since the cursor was last moved
          if (cur_col >= grid_cols()) cur_col = grid_cols() - 1;
          if (cur_row >= grid_rows()) cur_row = grid_rows() - 1;
          if (view_back > 0) begin
            view_back = 0;
            push(KIND_VIEW, 0, 0, 0, '0, '0);
          end
          if (it.char_code == ChNewline) begin
            cur_col = 0;
            line_feed();
          end else if (it.char_code == ChTab) begin
            pad = TabStop - (cur_col % TabStop);
            repeat (pad) write_cell(ChSpace);
          end else if (it.char_code == ChBackspace) begin
            if (cur_col > 0) begin
              cur_col--;
              push(KIND_CELL, cur_row, cur_col, ChSpace, fg_reg, bg_reg);
            end
          end else begin
            write_cell(it.char_code);
          end
          if (it.end_of_write) push(KIND_CURSOR, cur_row, cur_col, 0, '0, '0);
        end
        ACT_PAGE_UP: begin
          if (hist_lines > 0) begin
            view_back += grid_rows();
            if (view_back > hist_lines) view_back = hist_lines;
            push(KIND_VIEW, 0, 0, 0, '0, '0);
          end
        end
        ACT_PAGE_DOWN: begin
          if (view_back > 0) begin
            view_back = (view_back > grid_rows()) ? view_back - grid_rows() : 0;
            push(KIND_VIEW, 0, 0, 0, '0, '0);
          end
        end
        default: begin
          cur_col    = 0;
          cur_row    = 0;
          hist_lines = 0;
          view_back  = 0;
          push(KIND_CLEARED, 0, 0, 0, '0, '0);
        end
      endcase
      if (step_events.size() > 0) begin
        o = step_events.pop_back();
        o.last = 1'b1;
        step_events.push_back(o);
      end
      foreach (step_events[i]) pending_events.push_back(step_events[i]);
    endfunction

    function void check_field(string name, logic [7:0] exp, logic [7:0] act);
      if (exp !== act) begin
        $error("%s mismatch: expected %0d, got %0d", name, exp, act);
        errors++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp;
      if (pending_events.size() == 0) begin
        $error("unexpected result transaction: kind %0d", got.kind);
        errors++;
        return;
      end
      exp = pending_events.pop_front();
      check_field("kind", exp.kind, got.kind);
      check_field("row", exp.row, got.row);
      check_field("col", exp.col, got.col);
      check_field("glyph", exp.glyph, got.glyph);
      check_field("fg", exp.fg, got.fg);
      check_field("bg", exp.bg, got.bg);
      check_field("view_offset", exp.view_offset, got.view_offset);
      check_field("history_count", exp.history_count, got.history_count);
      check_field("last", exp.last, got.last);
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid = 1'b0;
  in_item_t   in_item = '0;
  logic       out_stall = 1'b0;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_COLUMNS;
  logic [7:0] cfg_data = '0;

  logic        in_stall_o;
  logic        out_valid_o;
  out_item_t   out_item_o;

  console_scoreboard sb = new();
  bit          calm = 1'b0;
  int unsigned quiet_cycles = 0;

  text_console_cursor_engine_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall),
    .out_item_o (out_item_o),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_stall <= !calm && ($urandom_range(99) < 12);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall_o) sb.note_input(in_item);
      if (out_valid_o && !out_stall) sb.check_result(out_item_o);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WatchdogLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic in_item_t make_item(action_e act, logic [7:0] ch, logic eow);
    in_item_t it;
    it.action       = act;
    it.char_code    = ch;
    it.end_of_write = eow;
    return it;
  endfunction

  function automatic in_item_t random_item(int unsigned tab_pct, int unsigned up_pct,
                                           int unsigned down_pct, int unsigned clear_pct);
    in_item_t    it;
    int unsigned pick;
    it.char_code    = 8'($urandom_range(255));
    it.end_of_write = ($urandom_range(99) < 30);
    pick = $urandom_range(99);
    if (pick < clear_pct) begin
      it.action = ACT_CLEAR;
    end else if (pick < clear_pct + up_pct) begin
      it.action = ACT_PAGE_UP;
    end else if (pick < clear_pct + up_pct + down_pct) begin
      it.action = ACT_PAGE_DOWN;
    end else begin
      it.action = ACT_BYTE;
      pick = $urandom_range(99);
      if (pick < tab_pct) it.char_code = ChTab;
      else if (pick < tab_pct + 12) it.char_code = ChNewline;
      else if (pick < tab_pct + 22) it.char_code = ChBackspace;
      else if (pick < tab_pct + 62) it.char_code = 8'($urandom_range(8'h7E, 8'h20));
    end
    return it;
  endfunction

  task automatic send_item(in_item_t it);
    if (!calm && ($urandom_range(99) < 12)) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // hold off until every predicted transaction is out and the queue has emptied
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending_events.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic apply_config(logic [7:0] cols, logic [7:0] rows,
                              logic [7:0] fg, logic [7:0] bg);
    cfg_idx_e   order [4] = '{CFG_COLUMNS, CFG_ROWS, CFG_FG, CFG_BG};
    logic [7:0] vals [4];
    vals = '{cols, rows, fg, bg};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= order[i];
      cfg_data  <= vals[i];
      @(posedge clk_i);
      sb.set_reg(order[i], vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(logic [7:0] cols, logic [7:0] rows, logic [7:0] fg,
                           logic [7:0] bg, int unsigned count, int unsigned tab_pct,
                           int unsigned up_pct, int unsigned down_pct,
                           int unsigned clear_pct);
    settle();
    apply_config(cols, rows, fg, bg);
    repeat (count) send_item(random_item(tab_pct, up_pct, down_pct, clear_pct));
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset geometry: edge cases of the cursor and empty history
    send_item(make_item(ACT_BYTE, ChBackspace, 1'b1));
    send_item(make_item(ACT_PAGE_DOWN, 8'h00, 1'b0));
    send_item(make_item(ACT_PAGE_UP, 8'hFF, 1'b1));
    send_item(make_item(ACT_BYTE, 8'h41, 1'b0));
    send_item(make_item(ACT_BYTE, 8'hFF, 1'b0));
    send_item(make_item(ACT_BYTE, 8'h00, 1'b1));
    send_item(make_item(ACT_BYTE, ChTab, 1'b1));
    send_item(make_item(ACT_BYTE, ChBackspace, 1'b0));
    send_item(make_item(ACT_BYTE, ChNewline, 1'b1));
    send_item(make_item(ACT_BYTE, 8'h42, 1'b0));
    send_item(make_item(ACT_BYTE, 8'h43, 1'b1));

    // zero-sized grid clamps to one cell: cursor is cut back, every byte scrolls
    settle();
    apply_config(8'd0, 8'd0, 8'd15, 8'hFF);
    send_item(make_item(ACT_BYTE, 8'h78, 1'b0));
    send_item(make_item(ACT_BYTE, 8'h79, 1'b0));
    send_item(make_item(ACT_BYTE, 8'h7A, 1'b1));
    send_item(make_item(ACT_PAGE_UP, 8'h00, 1'b0));
    send_item(make_item(ACT_PAGE_UP, 8'h00, 1'b0));
    send_item(make_item(ACT_PAGE_DOWN, 8'h00, 1'b0));
    send_item(make_item(ACT_BYTE, ChTab, 1'b1));
    send_item(make_item(ACT_PAGE_UP, 8'h00, 1'b0));
    send_item(make_item(ACT_PAGE_DOWN, 8'h00, 1'b1));
    send_item(make_item(ACT_PAGE_DOWN, 8'h00, 1'b0));
    send_item(make_item(ACT_CLEAR, 8'hFF, 1'b1));

    // one-cell grid, tab heavy: fills history up to its cap
    run_phase(8'd1, 8'd1, 8'($urandom), 8'($urandom), 90, 70, 5, 5, 0);
    // oversized registers clamp to the largest grid; page through full history
    run_phase(8'hFF, 8'hFF, 8'($urandom), 8'($urandom), 30, 10, 50, 15, 0);
    run_phase(8'd5, 8'd3, 8'($urandom), 8'($urandom), 45, 15, 12, 12, 3);
    settle();
    calm = 1'b1;
    run_phase(ColsDefault, RowsDefault, FgDefault, BgDefault, 40, 10, 12, 12, 3);
    settle();
    calm = 1'b0;
    run_phase(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 30, 15, 12, 12, 3);
    settle();

    if (sb.errors == 0 && sb.pending_events.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
